// File: rtl/core/rec_pkg.sv
package rec_pkg;

    localparam int unsigned LevelW = 3;
    localparam int unsigned HoldW  = 16;
    localparam int unsigned CodeW  = 4;
    localparam int unsigned EventW = 3;

    localparam logic [HoldW-1:0] LongPressReset = HoldW'(10);
    localparam logic [HoldW-1:0] HoldMax        = '1;

    localparam logic [0:0] RegLongPress = 1'b0;

    typedef enum logic [8:0] {
        ST_IDLE        = 9'b000000001,
        ST_START_RIGHT = 9'b000000010,
        ST_START_LEFT  = 9'b000000100,
        ST_ROT_RIGHT   = 9'b000001000,
        ST_ROT_LEFT    = 9'b000010000,
        ST_CLICK       = 9'b000100000,
        ST_LONG        = 9'b001000000,
        ST_SIMPLE      = 9'b010000000,
        ST_PUSH_ROTATE = 9'b100000000
    } t_state;

    typedef enum logic [EventW-1:0] {
        EV_NONE        = 3'd0,
        EV_BUTTON_RISE = 3'd1,
        EV_BUTTON_FALL = 3'd2,
        EV_LEFT_RISE   = 3'd3,
        EV_LEFT_FALL   = 3'd4,
        EV_RIGHT_RISE  = 3'd5,
        EV_RIGHT_FALL  = 3'd6
    } t_event;

    typedef enum logic [CodeW-1:0] {
        CODE_IDLE        = 4'd0,
        CODE_START_RIGHT = 4'd1,
        CODE_START_LEFT  = 4'd2,
        CODE_ROT_RIGHT   = 4'd3,
        CODE_ROT_LEFT    = 4'd4,
        CODE_CLICK       = 4'd5,
        CODE_LONG        = 4'd6,
        CODE_SIMPLE      = 4'd7,
        CODE_PUSH_ROTATE = 4'd8
    } t_code;

    // levels: bit 0 left, bit 1 right, bit 2 button
    typedef struct packed {
        t_state             state;
        logic [HoldW-1:0]   hold;
        t_event             ev;
    } t_step;

    function automatic t_code state_code(input t_state s);
        t_code c;
        case (s)
            ST_IDLE:        c = CODE_IDLE;
            ST_START_RIGHT: c = CODE_START_RIGHT;
            ST_START_LEFT:  c = CODE_START_LEFT;
            ST_ROT_RIGHT:   c = CODE_ROT_RIGHT;
            ST_ROT_LEFT:    c = CODE_ROT_LEFT;
            ST_CLICK:       c = CODE_CLICK;
            ST_LONG:        c = CODE_LONG;
            ST_SIMPLE:      c = CODE_SIMPLE;
            ST_PUSH_ROTATE: c = CODE_PUSH_ROTATE;
            default:        c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/rec_step.sv
module rec_step
    import rec_pkg::*;
(
    input  logic [LevelW-1:0] i_levels,
    input  logic [LevelW-1:0] i_prev,
    input  t_state            i_state,
    input  logic [HoldW-1:0]  i_hold,
    input  logic [HoldW-1:0]  i_long_press,
    output t_step             o_next
);

    t_event           ev;
    t_state           nstate;
    logic [HoldW-1:0] nhold;
    logic [HoldW-1:0] hold_inc;

    // right beats left beats button
    always_comb begin
        ev = EV_NONE;
        if (i_levels[1] != i_prev[1]) begin
            ev = i_levels[1] ? EV_RIGHT_RISE : EV_RIGHT_FALL;
        end else if (i_levels[0] != i_prev[0]) begin
            ev = i_levels[0] ? EV_LEFT_RISE : EV_LEFT_FALL;
        end else if (i_levels[2] != i_prev[2]) begin
            ev = i_levels[2] ? EV_BUTTON_RISE : EV_BUTTON_FALL;
        end
    end

    assign hold_inc = (i_hold == HoldMax) ? i_hold : i_hold + HoldW'(1);

    always_comb begin
        nstate = i_state;
        nhold  = i_hold;
        case (i_state)
            ST_IDLE: begin
                if (ev == EV_RIGHT_FALL) begin
                    nstate = ST_START_RIGHT;
                end else if (ev == EV_LEFT_FALL) begin
                    nstate = ST_START_LEFT;
                end else if (ev == EV_BUTTON_FALL) begin
                    nstate = ST_CLICK;
                end
            end
            ST_START_RIGHT: begin
                if (ev == EV_LEFT_FALL) begin
                    nstate = ST_ROT_RIGHT;
                end else if (ev == EV_RIGHT_RISE) begin
                    nstate = ST_IDLE;
                end
            end
            ST_START_LEFT: begin
                if (ev == EV_RIGHT_FALL) begin
                    nstate = ST_ROT_LEFT;
                end else if (ev == EV_LEFT_RISE) begin
                    nstate = ST_IDLE;
                end
            end
            ST_CLICK: begin
                nhold = hold_inc;
                if (hold_inc > i_long_press) begin
                    if (ev == EV_BUTTON_RISE) begin
                        nstate = ST_LONG;
                        nhold  = '0;
                    end
                end else if (ev == EV_BUTTON_RISE) begin
                    nstate = ST_SIMPLE;
                    nhold  = '0;
                end else if (ev inside {EV_LEFT_RISE, EV_RIGHT_RISE}) begin
                    nstate = ST_PUSH_ROTATE;
                    nhold  = '0;
                end
            end
            default: begin
                nstate = ST_IDLE;
            end
        endcase
    end

    assign o_next.state = nstate;
    assign o_next.hold  = nhold;
    assign o_next.ev    = ev;

endmodule

// File: rtl/core/rotary_encoder_click_decoder.sv
// Rotary encoder click decoder.
// s_* stream: one transfer per pin sample tick, s_tdata[0] left, [1] right,
//   [2] button, all active low. m_* stream: one transfer per input transfer,
//   m_tdata[3:0] machine state code, [6:4] edge event of that tick.
// APB port: register 0 at address 0 is the long press limit (16 bits, reset
//   10); a release counts as a long click once the hold count exceeds it.
// Path: an input transfer lands in the input register; the state update happens
//   as it moves into the output register, where its result is offered.
// Throughput: one transfer per cycle unless m_tready stalls the output, set by
//   the combinational step logic between the two registers.
// Reset: pins released, machine idle, hold count zero, both stages empty.
// Stall: while m_tready is low the result holds; one more sample is taken
//   into the input register, then s_tready drops until the output moves.
module rotary_encoder_click_decoder
    import rec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // left, right, button, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // fsm_state[3:0], edge_event[6:4], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              r_in_valid;
    logic [LevelW-1:0] r_in_levels;
    logic              r_out_valid;
    t_code             r_out_code;
    t_event            r_out_event;
    logic [LevelW-1:0] r_prev;
    t_state            r_state;
    logic [HoldW-1:0]  r_hold;
    logic [HoldW-1:0]  r_long_press;

    logic  advance;
    logic  in_xfer;
    t_step n_step;

    assign pready   = 1'b1;
    assign advance  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || advance;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb begin
        prdata = '0;
        if (paddr[2:2] == RegLongPress) begin
            prdata = {{(32-HoldW){1'b0}}, r_long_press};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press <= LongPressReset;
        end else if (psel && penable && pwrite && pready
                     && paddr[2:2] == RegLongPress) begin
            r_long_press <= pwdata[HoldW-1:0];
        end
    end

    rec_step u_step (
        .i_levels     (r_in_levels),
        .i_prev       (r_prev),
        .i_state      (r_state),
        .i_hold       (r_hold),
        .i_long_press (r_long_press),
        .o_next       (n_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_levels <= s_tdata[LevelW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev      <= '1;
            r_state     <= ST_IDLE;
            r_hold      <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_prev      <= r_in_levels;
                r_state     <= n_step.state;
                r_hold      <= n_step.hold;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_code  <= state_code(n_step.state);
            r_out_event <= n_step.ev;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {1'b0, r_out_event, r_out_code};

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("machine state not one-hot");

    a_hold_only_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold != '0 |-> r_state == ST_CLICK)
        else $error("hold count live outside click");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> m_tvalid)
        else $error("advanced item did not reach output");

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_code == state_code(r_state))
        else $error("output code differs from machine state");
`endif

endmodule
